@@ src/zci_pkg.sv @@
package zci_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int FRAC_W     = 16;
  localparam int POS_W      = 32;
  localparam int DIV_STEPS  = 17;
  localparam int DIV_CNT_W  = 5;
  localparam logic [SAMPLE_W-1:0] LEVEL_RESET = 16'h8000;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_HOLD
  } zci_state_t;

  typedef struct packed {
    logic                start;
    logic [SAMPLE_W-1:0] num;
    logic [SAMPLE_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

@@ src/zci_if.sv @@
interface zci_in_if import zci_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;
  logic                last_sample;

  modport source (output valid, output sample, output last_sample, input ready);
  modport sink (input valid, input sample, input last_sample, output ready);
endinterface

interface zci_out_if import zci_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             found;
  logic [POS_W-1:0] position_q16;

  modport source (output valid, output found, output position_q16, input ready);
  modport sink (input valid, input found, input position_q16, output ready);
endinterface

interface zci_cfg_if import zci_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ src/zero_crossing_interpolator_top.sv @@
// channel   modport  payload                      accepted when
// samples   sink     sample[15:0], last_sample    samples.valid && samples.ready
// results   source   found, position_q16[31:0]    results.valid && results.ready
// cfg       sink     data[15:0] (average level)   cfg.valid && cfg.ready
//
// A sample that gives no result leaves the block ready for the next sample; a not-found
// result passes through the hold state first. A crossing's fraction comes from a bit-serial
// divider that produces one of its 17 quotient bits per cycle.
// rst is synchronous, active high; level resets to 0x8000, block state to zero.
// samples.ready is low only while a result is being computed or is held for loading
// into the output register; cfg.ready is always high.
module zero_crossing_interpolator_top import zci_pkg::*; #(
  parameter int MAX_LEN = 65536
) (
  input  logic       clk,
  input  logic       rst,
  zci_in_if.sink     samples,
  zci_out_if.source  results,
  zci_cfg_if.sink    cfg
);

  localparam int IW = $clog2(MAX_LEN);
  localparam logic [IW-1:0] IDX_MAX = IW'(MAX_LEN - 1);

  zci_state_t          state;
  zci_state_t          state_next;
  logic [SAMPLE_W-1:0] level;
  logic [SAMPLE_W-1:0] prev;
  logic [IW-1:0]       index;
  logic                done_blk;
  logic [SAMPLE_W-1:0] base_idx;
  logic                hold_found;
  logic [POS_W-1:0]    hold_pos;
  logic                out_valid;
  logic                out_found;
  logic [POS_W-1:0]    out_pos;

  logic                accept;
  logic                hit;
  logic                miss;
  logic                out_free;
  logic                load_out;
  div_req_t            div_req;
  div_stat_t           div_stat;
  logic [FRAC_W:0]     quot;

  assign accept   = samples.valid && samples.ready;
  assign hit      = !done_blk && (index != '0) && (samples.sample >= level) && (prev < level);
  assign miss     = samples.last_sample && !done_blk && !hit;
  assign out_free = !out_valid || results.ready;

  assign div_req.start = accept && hit;
  assign div_req.num   = level - prev;
  assign div_req.den   = samples.sample - prev;

  zci_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .stat (div_stat),
    .quot (quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    samples.ready = 1'b0;
    load_out      = 1'b0;
    case (state)
      S_IDLE: begin
        samples.ready = 1'b1;
        if (accept && hit) begin
          state_next = S_DIV;
        end else if (accept && miss) begin
          state_next = S_HOLD;
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          state_next = S_HOLD;
        end
      end
      S_HOLD: begin
        if (out_free) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // block state
  always_ff @(posedge clk) begin
    if (rst) begin
      prev     <= '0;
      index    <= '0;
      done_blk <= 1'b0;
    end else if (accept) begin
      if (samples.last_sample) begin
        prev     <= '0;
        index    <= '0;
        done_blk <= 1'b0;
      end else begin
        prev <= samples.sample;
        if (index < IDX_MAX) begin
          index <= index + IW'(1);
        end
        if (hit) begin
          done_blk <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level <= LEVEL_RESET;
    end else if (cfg.valid) begin
      level <= cfg.data;
    end
  end
  assign cfg.ready = 1'b1;

  // pending result
  always_ff @(posedge clk) begin
    if (accept) begin
      hold_found <= hit;
      hold_pos   <= '0;
      base_idx   <= SAMPLE_W'(index) - SAMPLE_W'(1);
    end else if ((state == S_DIV) && div_stat.done) begin
      hold_pos <= {base_idx + SAMPLE_W'(quot[FRAC_W]), quot[FRAC_W-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_found <= hold_found;
      out_pos   <= hold_pos;
    end
  end

  assign results.valid        = out_valid;
  assign results.found        = out_found;
  assign results.position_q16 = out_pos;

`ifndef SYNTHESIS
  a_notfound_zero: assert property (@(posedge clk) disable iff (rst)
    (results.valid && !results.found) |-> (results.position_q16 == '0))
    else $error("not-found result with nonzero position");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == S_DIV))
    else $error("divider done outside division state");

  a_hit_starts_div: assert property (@(posedge clk) disable iff (rst)
    (accept && hit) |=> ((state == S_DIV) && div_stat.busy))
    else $error("crossing did not start division");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.found) |->
      (results.position_q16[31:16] <= SAMPLE_W'(MAX_LEN - 1)))
    else $error("position beyond saturated index");

  a_hold_div_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_HOLD) |-> !div_stat.busy)
    else $error("divider busy while result held");
`endif

endmodule

@@ src/zci_div.sv @@
module zci_div import zci_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  div_req_t        req,
  output div_stat_t       stat,
  output logic [FRAC_W:0] quot
);

  logic [DIV_CNT_W-1:0] cnt;
  logic                 done;
  logic [SAMPLE_W:0]    rem;
  logic [SAMPLE_W-1:0]  den;
  logic                 ge;
  logic [SAMPLE_W:0]    diff;
  logic [SAMPLE_W-1:0]  rem_sel;

  assign ge      = rem >= {1'b0, den};
  assign diff    = rem - {1'b0, den};
  assign rem_sel = ge ? diff[SAMPLE_W-1:0] : rem[SAMPLE_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= (cnt == DIV_CNT_W'(1));
      if (req.start) begin
        cnt <= DIV_CNT_W'(DIV_STEPS);
      end else if (cnt != '0) begin
        cnt <= cnt - DIV_CNT_W'(1);
      end
    end
  end

  // one quotient bit per cycle, restoring
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem  <= {1'b0, req.num};
      den  <= req.den;
      quot <= '0;
    end else if (cnt != '0) begin
      quot <= {quot[FRAC_W-1:0], ge};
      rem  <= {rem_sel, 1'b0};
    end
  end

  assign stat.busy = (cnt != '0);
  assign stat.done = done;

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
  import zci_pkg::*;

  localparam int MAX_LEN    = 65536;
  localparam int SETTLE_CYC = 40;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
  } crossing_report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  zci_in_if  samples ();
  zci_out_if results ();
  zci_cfg_if cfg ();

  zero_crossing_interpolator_top #(
    .MAX_LEN(MAX_LEN)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .samples(samples),
    .results(results),
    .cfg(cfg)
  );

  crossing_report_t    crossing_reports[$];
  crossing_report_t    want;
  logic [SAMPLE_W-1:0] avg_level;
  logic [SAMPLE_W-1:0] prev_smp;
  logic [SAMPLE_W-1:0] blk_idx;
  logic                crossed;

  int idle_pct;
  int stall_pct;
  int errors;
  int n_items;
  int n_found;
  int n_missed;
  int n_levels;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // track the block and predict the word, if any, that each sample produces
  function automatic void locate_crossing(logic [SAMPLE_W-1:0] cur, logic last);
    logic [POS_W-1:0]    num_q;
    logic [POS_W-1:0]    frac;
    logic [SAMPLE_W-1:0] den;
    crossing_report_t    rep;
    if (!crossed && blk_idx != 0 && cur >= avg_level && prev_smp < avg_level) begin
      num_q = {avg_level - prev_smp, 16'h0000};
      den = cur - prev_smp;
      frac = num_q / {16'h0000, den};
      rep.found = 1'b1;
      rep.position = {blk_idx - 16'd1, 16'h0000} + frac;
      crossing_reports.push_back(rep);
      crossed = 1'b1;
      n_found++;
    end else if (last && !crossed) begin
      rep.found = 1'b0;
      rep.position = '0;
      crossing_reports.push_back(rep);
      n_missed++;
    end
    if (last) begin
      prev_smp = '0;
      blk_idx = '0;
      crossed = 1'b0;
    end else begin
      prev_smp = cur;
      if (blk_idx != SAMPLE_W'(MAX_LEN - 1))
        blk_idx++;
    end
  endfunction

  always @(posedge clk) begin
    results.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && results.valid && results.ready) begin
      if (crossing_reports.size() == 0) begin
        $display("%0t: unexpected word found=%0b position=%08h", $time,
                 results.found, results.position_q16);
        errors++;
      end else begin
        want = crossing_reports.pop_front();
        if (results.found !== want.found) begin
          $display("%0t: found expected %0b actual %0b", $time, want.found,
                   results.found);
          errors++;
        end
        if (results.position_q16 !== want.position) begin
          $display("%0t: position expected %08h actual %08h", $time, want.position,
                   results.position_q16);
          errors++;
        end
      end
    end
  end

  task automatic send_sample(logic [SAMPLE_W-1:0] smp, logic last);
    while ($urandom_range(99) < idle_pct) begin
      samples.valid <= 1'b0;
      @(posedge clk);
    end
    samples.valid <= 1'b1;
    samples.sample <= smp;
    samples.last_sample <= last;
    do @(posedge clk); while (!samples.ready);
    locate_crossing(smp, last);
    n_items++;
  endtask

  // hold off until every word is back and the divider has gone quiet
  task automatic settle();
    samples.valid <= 1'b0;
    while (crossing_reports.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_level(logic [SAMPLE_W-1:0] lvl);
    cfg.valid <= 1'b1;
    cfg.data <= lvl;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    avg_level = lvl;
    n_levels++;
  endtask

  task automatic set_idling(int phase);
    case (phase % 4)
      0: begin
        idle_pct = 0;
        stall_pct = 0;
      end
      1: begin
        idle_pct = 51;
        stall_pct = 0;
      end
      2: begin
        idle_pct = 0;
        stall_pct = 51;
      end
      default: begin
        idle_pct = 9;
        stall_pct = 9;
      end
    endcase
  endtask

  task automatic test_reset_level();
    send_sample(16'h8000, 1'b1);
    send_sample(16'h0000, 1'b0);
    send_sample(16'hFFFF, 1'b1);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h0000, 1'b0);
    send_sample(16'hFFFF, 1'b1);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h9000, 1'b0);
    send_sample(16'h8001, 1'b1);
    settle();
  endtask

  task automatic test_level_extremes();
    write_level(16'h0000);
    send_sample(16'h0000, 1'b0);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h0000, 1'b1);
    settle();
    write_level(16'hFFFF);
    send_sample(16'hFFFE, 1'b0);
    send_sample(16'hFFFF, 1'b1);
    send_sample(16'h0000, 1'b0);
    send_sample(16'hFFFF, 1'b1);
    settle();
    write_level(16'h0001);
    send_sample(16'h0000, 1'b0);
    send_sample(16'h0002, 1'b0);
    send_sample(16'h5555, 1'b1);
    send_sample(16'hAAAA, 1'b1);
    settle();
  endtask

  task automatic test_long_block();
    write_level(16'h8000);
    set_idling(0);
    repeat (100) send_sample(16'hFFFF, 1'b0);
    send_sample(16'h0000, 1'b0);
    send_sample(16'h8000, 1'b1);
    repeat (20) send_sample(16'hFFFF, 1'b0);
    send_sample(16'hFFFF, 1'b1);
    settle();
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    int near;
    case ($urandom_range(7))
      0: return SAMPLE_W'($urandom_range(16'hFFFF));
      1: return avg_level;
      2: begin
        near = int'(avg_level) + $urandom_range(64) - 32;
        if (near < 0)
          near = 0;
        if (near > 16'hFFFF)
          near = 16'hFFFF;
        return SAMPLE_W'(near);
      end
      3: return 16'h0000;
      4: return 16'hFFFF;
      5: return (avg_level == 0) ? 16'h0000
                                 : SAMPLE_W'($urandom_range(int'(avg_level) - 1));
      default: return SAMPLE_W'($urandom_range(16'hFFFF, int'(avg_level)));
    endcase
  endfunction

  task automatic run_blocks(int count);
    int sent;
    int len;
    sent = 0;
    while (sent < count) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(60, 13) : $urandom_range(12, 1);
      for (int i = 0; i < len; i++)
        send_sample(pick_sample(), i == len - 1);
      sent += len;
    end
  endtask

  task automatic test_random_blocks();
    logic [SAMPLE_W-1:0] lvl;
    for (int seg = 0; seg < 8; seg++) begin
      case (seg)
        1: lvl = 16'h0000;
        2: lvl = 16'hFFFF;
        4: lvl = 16'h0001;
        5: lvl = 16'h8000;
        7: lvl = 16'hFFFE;
        default: lvl = SAMPLE_W'($urandom_range(16'hFFFF));
      endcase
      write_level(lvl);
      set_idling(seg);
      run_blocks(110);
      settle();
    end
  endtask

  initial begin
    samples.valid <= 1'b0;
    samples.sample <= '0;
    samples.last_sample <= 1'b0;
    cfg.valid <= 1'b0;
    cfg.data <= '0;
    idle_pct = 0;
    stall_pct = 0;
    errors = 0;
    n_items = 0;
    n_found = 0;
    n_missed = 0;
    n_levels = 0;
    avg_level = LEVEL_RESET;
    prev_smp = '0;
    blk_idx = '0;
    crossed = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_level();
    test_level_extremes();
    test_long_block();
    test_random_blocks();
    settle();

    $display("%0d samples sent, %0d crossings and %0d empty blocks checked,",
             n_items, n_found, n_missed);
    $display("%0d level writes including 0, 1, 0xFFFE, 0xFFFF and a 100-sample lead-in",
             n_levels);
    if (errors == 0)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout with %0d words outstanding", crossing_reports.size());
    $display("tb_top NOT OK");
    $finish;
  end

endmodule

@@ filelist.f @@
src/zci_pkg.sv
src/zci_if.sv
src/zci_div.sv
src/zero_crossing_interpolator_top.sv
sim/tb_top.sv
